// ===== rtl/tlife_pkg.sv =====
// shared constants, types and row helpers for the toroidal life block
package tlife_pkg;

   // board geometry
   localparam int ROWS = 32;
   localparam int COLS = 32;
   localparam int RIDX_W = $clog2(ROWS);

   // transaction field widths
   localparam int CMD_W = 2;
   localparam int IDX_W = 5;
   localparam int FIELD_W = 32;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 32;

   // command codes
   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ADVANCE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

   // life rule: birth on three, survival on two or three
   localparam logic [3:0] BIRTH_COUNT = 4'd3;
   localparam logic [3:0] SURVIVE_COUNT = 4'd2;

   // per-cell control
   typedef struct packed {
      logic load;
      logic step;
   } cell_ctrl_type;

   // fit a transaction row onto the board width, dropping columns past the edge
   function automatic logic [COLS-1:0] field_to_row(input logic [FIELD_W-1:0] cells);
      logic [COLS+FIELD_W-1:0] ext;
      ext = (COLS+FIELD_W)'(cells);
      return ext[COLS-1:0];
   endfunction

   // low columns of a board row as a transaction field
   function automatic logic [FIELD_W-1:0] row_to_field(input logic [COLS-1:0] row);
      logic [COLS+FIELD_W-1:0] ext;
      ext = (COLS+FIELD_W)'(row);
      return ext[FIELD_W-1:0];
   endfunction

endpackage

// ===== rtl/toroidal_life_automaton_unit.sv =====
// top level of the toroidal life block: row cell ring, read select and result stage
//
// Conway's life (B3/S23) on a ROWS by COLS torus held in a ring of row cells.
// Request channel (req_): tuser carries the command (write row, advance one
// generation, read row); tdata carries the row index and the row's cells.
// Result channel (rsp_): one transaction per request, in order; tdata is the
// row read (zero for any other command or a row past the board), tuser echoes
// the command.
// Each row cell sees the rows above and below it and computes its next
// generation in the accepting cycle, so an advance updates the whole board at
// once. The result is valid the cycle after the request is accepted, and a new
// request can be taken every cycle while the result stage has room.
// While the receiver stalls with a result held, req_tready drops until that
// result is taken; the board does not change meanwhile.
// Synchronous reset clears every cell to dead and empties the result stage;
// there is no clearing pass.
module toroidal_life_automaton_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [4:0] row_index, [36:5] row_cells, [39:37] zero
   input  logic [tlife_pkg::REQ_DATA_W-1:0]  req_tdata,
   // [1:0] command
   input  logic [tlife_pkg::CMD_W-1:0]       req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [31:0] row_cells_out
   output logic [tlife_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // [1:0] command_done
   output logic [tlife_pkg::CMD_W-1:0]       rsp_tuser
);
   import tlife_pkg::*;

   logic                  accept;
   logic                  free;
   logic [IDX_W-1:0]      row_index;
   logic [FIELD_W-1:0]    row_cells;
   logic [RIDX_W-1:0]     sel_idx;
   logic                  in_range;
   logic [COLS-1:0]       write_row;
   logic [COLS-1:0]       board_rows [ROWS];
   logic [RSP_DATA_W-1:0] result_data;

   // request fields
   assign row_index = req_tdata[IDX_W-1:0];
   assign row_cells = req_tdata[IDX_W+FIELD_W-1:IDX_W];
   assign accept = req_tvalid && req_tready;
   assign req_tready = free;
   assign sel_idx = RIDX_W'(row_index);
   assign in_range = 32'(row_index) < ROWS;
   assign write_row = field_to_row(row_cells);

   // ring of row cells, each wired to the rows above and below with wraparound
   for (genvar r = 0; r < ROWS; r++) begin : g_row
      cell_ctrl_type ctrl;
      assign ctrl.load = accept && (req_tuser == CMD_WRITE) && in_range
                       && (sel_idx == RIDX_W'(r));
      assign ctrl.step = accept && (req_tuser == CMD_ADVANCE);
      tlife_row_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .load_row (write_row),
         .up_row   (board_rows[(r == 0) ? ROWS - 1 : r - 1]),
         .down_row (board_rows[(r == ROWS - 1) ? 0 : r + 1]),
         .row_out  (board_rows[r])
      );
   end

   // read select
   always_comb begin
      result_data = '0;
      if ((req_tuser == CMD_READ) && in_range) begin
         result_data = row_to_field(board_rows[sel_idx]);
      end
   end

   tlife_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .load_data  (result_data),
      .load_cmd   (req_tuser),
      .free       (free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

`ifndef ASSERT_OFF
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_tvalid)
      else $error("accepted request gave no result");

   a_cmd_echo: assert property (@(posedge clock) disable iff (reset)
      accept |=> (rsp_tuser == $past(req_tuser)))
      else $error("result command differs from request");

   a_non_read_zero: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_tuser != CMD_READ)) |=> (rsp_tdata == '0))
      else $error("non-read result carries data");

   a_out_of_range_zero: assert property (@(posedge clock) disable iff (reset)
      (accept && !in_range) |=> (rsp_tdata == '0))
      else $error("read past the board returned data");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result stage not empty after reset");
`endif

endmodule

// ===== rtl/tlife_row_cell.sv =====
// one board row: holds its cells and computes its next generation from its neighbours
module tlife_row_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  tlife_pkg::cell_ctrl_type      ctrl,
   input  logic [tlife_pkg::COLS-1:0]    load_row,
   input  logic [tlife_pkg::COLS-1:0]    up_row,
   input  logic [tlife_pkg::COLS-1:0]    down_row,
   output logic [tlife_pkg::COLS-1:0]    row_out
);
   import tlife_pkg::*;

   logic [COLS-1:0] row_ff;
   logic [COLS-1:0] row_in;
   logic [COLS-1:0] next_gen;

   // neighbour count and rule for every column, wrapping at both edges
   always_comb begin
      int cl;
      int cr;
      logic [3:0] n;
      next_gen = '0;
      for (int c = 0; c < COLS; c++) begin
         cl = (c == 0) ? COLS - 1 : c - 1;
         cr = (c == COLS - 1) ? 0 : c + 1;
         n = 4'(up_row[cl]) + 4'(up_row[c]) + 4'(up_row[cr])
           + 4'(row_ff[cl]) + 4'(row_ff[cr])
           + 4'(down_row[cl]) + 4'(down_row[c]) + 4'(down_row[cr]);
         next_gen[c] = (n == BIRTH_COUNT) || (row_ff[c] && (n == SURVIVE_COUNT));
      end
   end

   // next row value
   always_comb begin
      row_in = row_ff;
      if (ctrl.load) begin
         row_in = load_row;
      end else if (ctrl.step) begin
         row_in = next_gen;
      end
   end

   // row register, all dead after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
      end else begin
         row_ff <= row_in;
      end
   end

   assign row_out = row_ff;

endmodule

// ===== rtl/tlife_out_stage.sv =====
// result register that holds a finished transaction until the receiver takes it
module tlife_out_stage (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              load,
   input  logic [tlife_pkg::RSP_DATA_W-1:0]  load_data,
   input  logic [tlife_pkg::CMD_W-1:0]       load_cmd,
   output logic                              free,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [tlife_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic [tlife_pkg::CMD_W-1:0]       rsp_tuser
);
   import tlife_pkg::*;

   logic                  valid_ff;
   logic                  valid_in;
   logic [RSP_DATA_W-1:0] data_ff;
   logic [CMD_W-1:0]      cmd_ff;

   // room for a new result when empty or when the held one leaves now
   assign free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   // valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
         cmd_ff <= load_cmd;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata = data_ff;
   assign rsp_tuser = cmd_ff;

endmodule

// ===== tb/toroidal_life_automaton_unit_tb.sv =====
// self-checking testbench for the toroidal life block: driver, board predictor, monitor
`timescale 1ns / 1ps

module toroidal_life_automaton_unit_tb;
   import tlife_pkg::*;

   // spare command code, not decoded by the block
   localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

   localparam int RANDOM_ITEMS = 2000;
   localparam int LIMIT_CYCLES = 400000;
   localparam int END_CYCLES = 16;

   // 3x3 shapes, bit 3*row+col set for a live cell
   localparam logic [8:0] SHAPE_GLIDER = 9'b111_100_010;
   localparam logic [8:0] SHAPE_BLINKER = 9'b000_000_111;
   localparam logic [8:0] SHAPE_BLOCK = 9'b000_011_011;

   typedef struct {
      logic [CMD_W-1:0]   cmd;
      logic [IDX_W-1:0]   row;
      logic [FIELD_W-1:0] cells;
      bit                 drain;
   } life_request_type;

   typedef struct {
      logic [FIELD_W-1:0] cells;
      logic [CMD_W-1:0]   cmd;
   } life_response_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [CMD_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b1;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [CMD_W-1:0] rsp_tuser;

   // predictor state and scoreboard
   logic [COLS-1:0] board_model [ROWS];
   logic [FIELD_W-1:0] scene_rows [ROWS];
   life_request_type pending_requests [$];
   life_response_type expected_responses [$];
   life_request_type request_in_flight;

   int failures = 0;
   int results_checked = 0;
   int cycle_count = 0;
   int requests_sent = 0;
   int gap_left = 0;
   int stall_left = 0;
   bit sender_quiet = 1'b0;
   bit receiver_quiet = 1'b0;
   int cmd_count [4] = '{0, 0, 0, 0};

   toroidal_life_automaton_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #2 clock = ~clock;

   // one generation of B3/S23 over the whole torus, all cells at once
   function automatic void life_generation();
      logic [COLS-1:0] next_rows [ROWS];
      int up, dn, cl, cr, n;
      for (int r = 0; r < ROWS; r++) begin
         up = (r + ROWS - 1) % ROWS;
         dn = (r + 1) % ROWS;
         for (int c = 0; c < COLS; c++) begin
            cl = (c + COLS - 1) % COLS;
            cr = (c + 1) % COLS;
            n = board_model[up][cl] + board_model[up][c] + board_model[up][cr]
              + board_model[r][cl] + board_model[r][cr]
              + board_model[dn][cl] + board_model[dn][c] + board_model[dn][cr];
            if (board_model[r][c])
               next_rows[r][c] = (n == SURVIVE_COUNT) || (n == BIRTH_COUNT);
            else
               next_rows[r][c] = (n == BIRTH_COUNT);
         end
      end
      board_model = next_rows;
   endfunction

   // apply one command to the board model and return the expected result
   function automatic life_response_type board_request(life_request_type rq);
      life_response_type rs;
      rs.cells = '0;
      rs.cmd = rq.cmd;
      case (rq.cmd)
         CMD_WRITE: begin
            if (rq.row < ROWS)
               for (int c = 0; c < COLS; c++)
                  board_model[rq.row][c] = (c < FIELD_W) ? rq.cells[c] : 1'b0;
         end
         CMD_ADVANCE: life_generation();
         CMD_READ: begin
            if (rq.row < ROWS)
               for (int c = 0; c < FIELD_W; c++)
                  rs.cells[c] = (c < COLS) ? board_model[rq.row][c] : 1'b0;
         end
         default: ;
      endcase
      return rs;
   endfunction

   task automatic queue_request(logic [CMD_W-1:0] cmd, int row, logic [FIELD_W-1:0] cells,
                                bit drain = 1'b0);
      life_request_type rq;
      rq.cmd = cmd;
      rq.row = IDX_W'(row);
      rq.cells = cells;
      rq.drain = drain;
      pending_requests.push_back(rq);
   endtask

   // occasional stray command between the well-formed ones
   task automatic maybe_noise();
      if ($urandom_range(0, 9) == 0)
         queue_request(CMD_W'($urandom_range(0, 3)), $urandom_range(0, 31), $urandom);
   endtask

   // stamp a 3x3 shape onto the scene, wrapping at the edges
   task automatic add_shape(logic [8:0] shape, int r0, int c0);
      for (int dr = 0; dr < 3; dr++)
         for (int dc = 0; dc < 3; dc++)
            if (shape[3*dr+dc])
               scene_rows[(r0 + dr) % ROWS][(c0 + dc) % COLS] = 1'b1;
   endtask

   function automatic logic [8:0] pick_shape();
      case ($urandom_range(0, 3))
         0: return SHAPE_GLIDER;
         1: return SHAPE_BLINKER;
         2: return SHAPE_BLOCK;
         default: return 9'($urandom);
      endcase
   endfunction

   function automatic int edge_pick(int size);
      case ($urandom_range(0, 2))
         0: return size - 2;
         1: return size - 1;
         default: return 0;
      endcase
   endfunction

   // load a pattern, run some generations, read rows back
   task automatic build_scene();
      int kind, density, n_gen;
      logic [FIELD_W-1:0] row_bits;
      bit hold;
      kind = $urandom_range(0, 3);
      hold = ($urandom_range(0, 4) == 0);
      for (int r = 0; r < ROWS; r++)
         scene_rows[r] = '0;
      case (kind)
         0: begin
            // random soup of varying density
            density = $urandom_range(0, 2);
            for (int r = 0; r < ROWS; r++) begin
               row_bits = $urandom;
               if (density == 0)
                  row_bits = row_bits & $urandom;
               else if (density == 2)
                  row_bits = row_bits | $urandom;
               scene_rows[r] = row_bits;
            end
         end
         1: repeat ($urandom_range(1, 6))
               add_shape(pick_shape(), $urandom_range(0, ROWS - 1), $urandom_range(0, COLS - 1));
         2: repeat ($urandom_range(1, 3))
               add_shape(pick_shape(), edge_pick(ROWS), edge_pick(COLS));
         default: ;
      endcase
      if (kind == 3) begin
         // rewrite a few rows over whatever the board holds
         queue_request(CMD_WRITE, $urandom_range(0, ROWS - 1), $urandom, hold);
         repeat ($urandom_range(0, 5))
            queue_request(CMD_WRITE, $urandom_range(0, ROWS - 1), $urandom);
      end else begin
         for (int r = 0; r < ROWS; r++) begin
            queue_request(CMD_WRITE, r, scene_rows[r], hold && (r == 0));
            maybe_noise();
         end
      end
      n_gen = (kind == 0) ? $urandom_range(1, 12) : $urandom_range(1, 6);
      repeat (n_gen) begin
         queue_request(CMD_ADVANCE, $urandom_range(0, 31), $urandom);
         repeat ($urandom_range(0, 3))
            queue_request(CMD_READ, $urandom_range(0, ROWS - 1), $urandom);
         maybe_noise();
      end
      if ($urandom_range(0, 1)) begin
         for (int r = 0; r < ROWS; r++)
            queue_request(CMD_READ, r, $urandom);
      end else begin
         repeat (8)
            queue_request(CMD_READ, $urandom_range(0, ROWS - 1), $urandom);
      end
   endtask

   // request driver: one transaction per pending item, random gaps between them
   always @(posedge clock) begin : request_driver
      life_request_type head;
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_responses.push_back(board_request(request_in_flight));
            cmd_count[request_in_flight.cmd]++;
         end
         if (!(req_tvalid && !req_tready)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_requests.size() > 0 &&
                         !(pending_requests[0].drain && expected_responses.size() > 0)) begin
               head = pending_requests.pop_front();
               request_in_flight = head;
               req_tvalid <= 1'b1;
               req_tdata <= REQ_DATA_W'({head.cells, head.row});
               req_tuser <= head.cmd;
               requests_sent++;
               if (requests_sent % 50 == 0)
                  sender_quiet = ($urandom_range(0, 2) == 0);
               gap_left = sender_quiet ? 0 : $urandom_range(0, 8);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor: compare against the oldest expectation, stall at random
   always @(posedge clock) begin : result_monitor
      life_response_type want;
      if (reset) begin
         rsp_tready <= 1'b1;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_checked++;
            if (expected_responses.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual data %h cmd %0d",
                        $time, rsp_tdata, rsp_tuser);
               failures++;
            end else begin
               want = expected_responses.pop_front();
               if (rsp_tdata !== want.cells) begin
                  $display("%0t: row_cells_out mismatch, expected %h, actual %h",
                           $time, want.cells, rsp_tdata);
                  failures++;
               end
               if (rsp_tuser !== want.cmd) begin
                  $display("%0t: command_done mismatch, expected %0d, actual %0d",
                           $time, want.cmd, rsp_tuser);
                  failures++;
               end
            end
            if (results_checked % 64 == 0)
               receiver_quiet = ($urandom_range(0, 2) == 0);
            stall_left = receiver_quiet ? 0 : $urandom_range(0, 8);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("%0t: timeout after %0d cycles, %0d results outstanding",
                  $time, cycle_count, expected_responses.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      int directed_count;
      for (int r = 0; r < ROWS; r++)
         board_model[r] = '0;

      // directed: reset state, full rows, edge columns, wraparound, spare command
      queue_request(CMD_READ, 0, '0, 1'b1);
      queue_request(CMD_WRITE, 0, 32'hFFFF_FFFF);
      queue_request(CMD_WRITE, 31, 32'hFFFF_FFFF);
      queue_request(CMD_READ, 31, 32'hFFFF_FFFF);
      queue_request(CMD_WRITE, 1, 32'h8000_0001);
      queue_request(CMD_READ, 1, '0);
      queue_request(CMD_ADVANCE, 31, 32'hFFFF_FFFF);
      queue_request(CMD_READ, 0, '0);
      queue_request(CMD_READ, 1, '0);
      queue_request(CMD_READ, 30, '0);
      queue_request(CMD_READ, 31, '0);
      queue_request(CMD_SPARE, 31, 32'hFFFF_FFFF);
      queue_request(CMD_SPARE, 0, '0);
      // blinker straddling the corner of the torus
      queue_request(CMD_WRITE, 30, '0);
      queue_request(CMD_WRITE, 31, '0);
      queue_request(CMD_WRITE, 1, '0);
      queue_request(CMD_WRITE, 0, 32'h8000_0003);
      queue_request(CMD_ADVANCE, 0, '0);
      queue_request(CMD_READ, 31, '0);
      queue_request(CMD_READ, 0, '0);
      queue_request(CMD_READ, 1, '0);
      queue_request(CMD_ADVANCE, 0, '0);
      queue_request(CMD_READ, 0, '0, 1'b1);
      directed_count = pending_requests.size();

      // random scenes until the item budget is used
      while (pending_requests.size() < directed_count + RANDOM_ITEMS)
         build_scene();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (pending_requests.size() > 0 || req_tvalid || expected_responses.size() > 0)
         @(posedge clock);
      repeat (END_CYCLES) @(posedge clock);

      $display("covered %0d writes, %0d advances, %0d reads, %0d spare commands",
               cmd_count[CMD_WRITE], cmd_count[CMD_ADVANCE], cmd_count[CMD_READ],
               cmd_count[CMD_SPARE]);
      $display("%0d results compared in %0d cycles, %0d mismatches",
               results_checked, cycle_count, failures);
      if (failures == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== toroidal_life_automaton_unit.f =====
rtl/tlife_pkg.sv
rtl/tlife_row_cell.sv
rtl/tlife_out_stage.sv
rtl/toroidal_life_automaton_unit.sv
tb/toroidal_life_automaton_unit_tb.sv
